>>> hdl/int_to_decimal_ascii_assert.svh
// Assertion macros shared by the RTL files.
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef SYNTHESIS
`define ITDA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ITDA_ASSERT(lbl, clk, rst_n, prop)
`define ITDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/itda_pkg.sv
`default_nettype none
package itda_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned MAX_DIGITS  = 10;
    localparam int unsigned ND_W        = $clog2(MAX_DIGITS + 1);
    localparam int unsigned IDX_W       = $clog2(MAX_DIGITS);
    // q = (x * RECIP) >> RECIP_SHIFT equals x / 10 for every 32-bit x
    localparam logic [DATA_W-1:0] RECIP = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;
    localparam int unsigned QUOT_W      = 2 * DATA_W - RECIP_SHIFT;
    localparam logic [7:0]  ASCII_ZERO  = 8'd48;
    localparam logic [7:0]  ASCII_MINUS = 8'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SIGN,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic mul;
        logic div;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic q_zero;
        logic nd_full;
        logic neg;
        logic idx_zero;
    } t_status;

endpackage
`default_nettype wire

>>> hdl/itda_dp.sv
`default_nettype none
`include "int_to_decimal_ascii_assert.svh"
module itda_dp
    import itda_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [DATA_W-1:0]  i_value,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    output logic                    o_valid,
    output logic [7:0]              o_char_code,
    output logic                    o_last
);

    logic [DATA_W-1:0]   r_mag;
    logic [QUOT_W-1:0]   r_prod;
    logic                r_neg;
    logic [3:0]          r_digits [MAX_DIGITS];
    logic [ND_W-1:0]     r_nd;
    logic [IDX_W-1:0]    r_idx;

    logic [2*DATA_W-1:0] w_prod;
    logic [DATA_W-1:0]   w_q10;
    logic [DATA_W-1:0]   w_rem;
    logic [DATA_W-1:0]   w_abs;

    assign w_abs  = i_value[DATA_W-1] ? (DATA_W'(0) - i_value) : i_value;
    assign w_prod = (2*DATA_W)'(r_mag) * (2*DATA_W)'(RECIP);
    // quotient times ten as 8q + 2q
    assign w_q10  = DATA_W'({r_prod, 3'b000}) + DATA_W'({r_prod, 1'b0});
    assign w_rem  = r_mag - w_q10;

    assign o_status.q_zero   = (r_prod == '0);
    assign o_status.nd_full  = (r_nd == ND_W'(MAX_DIGITS - 1));
    assign o_status.neg      = r_neg;
    assign o_status.idx_zero = (r_idx == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= w_abs;
            r_neg <= i_value[DATA_W-1];
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod[2*DATA_W-1:RECIP_SHIFT];
        end
        if (i_cmd.div) begin
            r_digits[r_nd[IDX_W-1:0]] <= w_rem[3:0];
            r_mag <= DATA_W'(r_prod);
            r_idx <= r_nd[IDX_W-1:0];
        end
        if (i_cmd.emit_digit) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        if (i_cmd.emit_sign) begin
            o_char_code <= ASCII_MINUS;
            o_last      <= 1'b0;
        end else begin
            o_char_code <= ASCII_ZERO + {4'b0000, r_digits[r_idx]};
            o_last      <= (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd    <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_sign | i_cmd.emit_digit;
            if (i_cmd.load) begin
                r_nd <= '0;
            end else if (i_cmd.div) begin
                r_nd <= r_nd + ND_W'(1);
            end
        end
    end

    `ITDA_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_valid && o_last, !o_valid)
    `ITDA_ASSERT(a_nd_bound, i_clk, i_rst_n, !i_cmd.div || (r_nd < ND_W'(MAX_DIGITS)))
    `ITDA_ASSERT(a_sign_not_last, i_clk, i_rst_n, !(o_valid && o_char_code == ASCII_MINUS && o_last))

endmodule
`default_nettype wire

>>> hdl/itda_ctrl.sv
`default_nettype none
`include "int_to_decimal_ascii_assert.svh"
module itda_ctrl
    import itda_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire t_status i_status,
    output logic         o_busy,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.q_zero || i_status.nd_full) begin
                    n_state = i_status.neg ? S_SIGN : S_DIGIT;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = S_DIGIT;
            end
            S_DIGIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_status.idx_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    `ITDA_ASSERT_NEXT(a_accept_to_mul, i_clk, i_rst_n, i_start && !o_busy, r_state == S_MUL)
    `ITDA_ASSERT_NEXT(a_mul_to_div, i_clk, i_rst_n, r_state == S_MUL, r_state == S_DIV)
    `ITDA_ASSERT_NEXT(a_done, i_clk, i_rst_n, r_state == S_DIGIT && i_status.idx_zero, r_state == S_IDLE)

endmodule
`default_nettype wire

>>> hdl/int_to_decimal_ascii.sv
`default_nettype none
// Signed 32-bit integer to decimal ASCII. Pulse start with i_value while busy is low;
// the text then leaves one character per o_valid pulse, sign first, no leading zeros,
// o_last on the final digit. The receiver cannot stall: every o_valid pulse is a
// transfer and must be taken. Digits are peeled least significant first by a shared
// reciprocal multiplier, in a multiply state and a divide state for each digit, then
// emitted one per cycle.
module int_to_decimal_ascii
    import itda_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] i_value,
    output logic                   busy,
    output logic                   o_valid,
    output logic [7:0]             o_char_code,
    output logic                   o_last
);

    t_cmd    w_cmd;
    t_status w_status;

    itda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    itda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
